// ===== src/cfbr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfbr_pkg
// Shared sizes, codes and control structs of the convolution core.
// ----------------------------------------------------------------------------
package cfbr_pkg;

    // Store geometry
    localparam int MAX_ROWS       = 32;
    localparam int MAX_COLUMNS    = 32;
    localparam int CHANNELS       = 8;
    localparam int KERNEL_ROWS    = 3;
    localparam int KERNEL_COLUMNS = 3;
    localparam int FILTERS        = 16;

    localparam int PIX_DEPTH = MAX_ROWS * MAX_COLUMNS * CHANNELS;
    localparam int WGT_DEPTH = FILTERS * KERNEL_ROWS * KERNEL_COLUMNS * CHANNELS;
    localparam int TAPS      = KERNEL_ROWS * KERNEL_COLUMNS * CHANNELS;

    localparam int PIX_AW  = $clog2(PIX_DEPTH);
    localparam int WGT_AW  = $clog2(WGT_DEPTH);
    localparam int BIAS_AW = (FILTERS > 1) ? $clog2(FILTERS) : 1;
    localparam int IR_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int IC_W    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int KR_W    = (KERNEL_ROWS > 1) ? $clog2(KERNEL_ROWS) : 1;
    localparam int KC_W    = (KERNEL_COLUMNS > 1) ? $clog2(KERNEL_COLUMNS) : 1;
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths
    localparam int REQ_TYPE_W = 2;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 5;
    localparam int CHAN_W     = 3;
    localparam int FILT_W     = 4;
    localparam int TAP_W      = 2;
    localparam int DATA_W     = 16;
    localparam int PROD_W     = 2 * DATA_W;

    // Configuration register widths
    localparam int DIM_W     = 6;
    localparam int PAD_W     = 2;
    localparam int STEP_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 6;

    // Signed window position: output index times step, less padding
    localparam int POS_W = ROW_W + STEP_W + 1;

    // Accumulator: full-precision products plus growth over the window and bias
    localparam int ACC_W = PROD_W + $clog2(TAPS) + 2;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_PIXEL   = 2'd0,
        REQ_WEIGHT  = 2'd1,
        REQ_BIAS    = 2'd2,
        REQ_COMPUTE = 2'd3
    } t_req_type;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_HEIGHT    = 3'd0,
        CFG_IMAGE_WIDTH     = 3'd1,
        CFG_PAD_ROWS        = 3'd2,
        CFG_PAD_COLUMNS     = 3'd3,
        CFG_VERTICAL_STEP   = 3'd4,
        CFG_HORIZONTAL_STEP = 3'd5,
        CFG_BIAS_ENABLE     = 3'd6,
        CFG_RELU_ENABLE     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_req_type                req_type;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic [CHAN_W-1:0]        chan;
        logic [FILT_W-1:0]        filter_index;
        logic [TAP_W-1:0]         tap_row;
        logic [TAP_W-1:0]         tap_column;
        logic signed [DATA_W-1:0] data_value;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     saturated;
        logic                     position_invalid;
    } t_res;

    // Controller to datapath
    typedef struct packed {
        logic            accept;
        logic            prep;
        logic            issue;
        logic [KR_W-1:0] kr;
        logic [KC_W-1:0] kc;
        logic [CH_W-1:0] ch;
        logic            add_bias;
        logic            load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pos_ok;
        logic pipe_busy;
        logic out_free;
    } t_sts;

endpackage

// ===== src/cfbr_req_if.sv =====
// ----------------------------------------------------------------------------
// cfbr_req_if
// Request channel: store writes and compute requests, valid/ready.
// ----------------------------------------------------------------------------
interface cfbr_req_if import cfbr_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [REQ_TYPE_W-1:0]    req_type;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic [CHAN_W-1:0]        chan;
    logic [FILT_W-1:0]        filter_index;
    logic [TAP_W-1:0]         tap_row;
    logic [TAP_W-1:0]         tap_column;
    logic signed [DATA_W-1:0] data_value;

    modport source (
        output valid, req_type, row, col, chan, filter_index, tap_row, tap_column,
               data_value,
        input  ready
    );

    modport sink (
        input  valid, req_type, row, col, chan, filter_index, tap_row, tap_column,
               data_value,
        output ready
    );

endinterface

// ===== src/cfbr_res_if.sv =====
// ----------------------------------------------------------------------------
// cfbr_res_if
// Result channel: one output element per compute request, valid/ready.
// ----------------------------------------------------------------------------
interface cfbr_res_if import cfbr_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_value;
    logic                     saturated;
    logic                     position_invalid;

    modport source (
        output valid, result_value, saturated, position_invalid,
        input  ready
    );

    modport sink (
        input  valid, result_value, saturated, position_invalid,
        output ready
    );

endinterface

// ===== src/conv2d_forward_bias_relu_core.sv =====
// ----------------------------------------------------------------------------
// conv2d_forward_bias_relu_core
// Single-element 2D convolution with zero padding, stride, optional bias and
// ReLU in Q7.8 fixed point, fed by store-write and compute requests.
//
//   Channel   Dir  Handshake    Payload
//   i_req     in   valid/ready  req_type, row, col, chan, filter_index,
//                               tap_row, tap_column, data_value
//   o_res     out  valid/ready  result_value, saturated, position_invalid
//   cfg       in   i_cfg_we     i_cfg_index, i_cfg_data
//
// A store write gives no result and leaves the sequencer idle. A compute
// request holds the request port through a check step, one tap per cycle for
// KERNEL_ROWS*KERNEL_COLUMNS*CHANNELS (72) taps through the single read port
// of each store, a drain of the multiply pipeline, a bias step and a result
// load. A position out of range goes from the check to the result load. The
// result register lets the next request in while a result waits; a stalled
// output holds the sequencer only at the result load. Reset is synchronous;
// store contents are undefined until written.
// ----------------------------------------------------------------------------
module conv2d_forward_bias_relu_core import cfbr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    cfbr_req_if.sink             i_req,
    cfbr_res_if.source           o_res
);

    t_req req;
    t_cmd cmd;
    t_sts sts;
    t_res res;
    logic req_ready;
    logic res_valid;

    // Gather the request payload
    assign req.req_type     = t_req_type'(i_req.req_type);
    assign req.row          = i_req.row;
    assign req.col          = i_req.col;
    assign req.chan         = i_req.chan;
    assign req.filter_index = i_req.filter_index;
    assign req.tap_row      = i_req.tap_row;
    assign req.tap_column   = i_req.tap_column;
    assign req.data_value   = i_req.data_value;

    assign i_req.ready = req_ready;

    cfbr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (req.req_type),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cfbr_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res_valid (res_valid),
        .i_res_ready (o_res.ready),
        .o_res       (res)
    );

    // Drive the result channel
    assign o_res.valid            = res_valid;
    assign o_res.result_value     = res.result_value;
    assign o_res.saturated        = res.saturated;
    assign o_res.position_invalid = res.position_invalid;

endmodule

// ===== src/cfbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfbr_ctrl
// Sequencer: walks the kernel window and channels, one tap per cycle, and
// steps the datapath through check, accumulate, drain, bias and result load.
// ----------------------------------------------------------------------------
module cfbr_ctrl import cfbr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    input  t_req_type i_req_type,
    output logic      o_req_ready,
    input  t_sts      i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PREP  = 6'b000010,
        S_RUN   = 6'b000100,
        S_DRAIN = 6'b001000,
        S_BIAS  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [KR_W-1:0] r_kr, n_kr;
    logic [KC_W-1:0] r_kc, n_kc;
    logic [CH_W-1:0] r_ch, n_ch;

    logic last_ch, last_kc, last_kr, accept;

    assign last_ch = (r_ch == CH_W'(CHANNELS - 1));
    assign last_kc = (r_kc == KC_W'(KERNEL_COLUMNS - 1));
    assign last_kr = (r_kr == KR_W'(KERNEL_ROWS - 1));

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;

    // Next state and window counters
    always_comb begin
        n_state = r_state;
        n_kr    = r_kr;
        n_kc    = r_kc;
        n_ch    = r_ch;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_req_type == REQ_COMPUTE)) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_kr = '0;
                n_kc = '0;
                n_ch = '0;
                n_state = i_sts.pos_ok ? S_RUN : S_OUT;
            end
            S_RUN: begin
                // advance channel fastest, then kernel column, then kernel row
                if (last_ch) begin
                    n_ch = '0;
                    if (last_kc) begin
                        n_kc = '0;
                        if (last_kr) begin
                            n_kr    = '0;
                            n_state = S_DRAIN;
                        end else begin
                            n_kr = r_kr + 1'b1;
                        end
                    end else begin
                        n_kc = r_kc + 1'b1;
                    end
                end else begin
                    n_ch = r_ch + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_BIAS;
                end
            end
            S_BIAS: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = accept;
        o_cmd.prep     = (r_state == S_PREP);
        o_cmd.issue    = (r_state == S_RUN);
        o_cmd.kr       = r_kr;
        o_cmd.kc       = r_kc;
        o_cmd.ch       = r_ch;
        o_cmd.add_bias = (r_state == S_BIAS);
        o_cmd.load_out = (r_state == S_OUT) && i_sts.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kr    <= '0;
            r_kc    <= '0;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_kr    <= n_kr;
            r_kc    <= n_kc;
            r_ch    <= n_ch;
        end
    end

endmodule

// ===== src/cfbr_dpath.sv =====
// ----------------------------------------------------------------------------
// cfbr_dpath
// Stores, configuration registers, tap address generation, multiply and
// accumulate pipeline, bias/ReLU/rounding and the result register.
// ----------------------------------------------------------------------------
module cfbr_dpath import cfbr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  t_req                 i_req,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output t_res                 o_res
);

    localparam logic signed [ACC_W-1:0] Q_MAX = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] Q_MIN = {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(128);

    // Configuration registers
    logic [DIM_W-1:0]  r_img_h, r_img_w;
    logic [PAD_W-1:0]  r_pad_r, r_pad_c;
    logic [STEP_W-1:0] r_step_v, r_step_h;
    logic              r_bias_en, r_relu_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_h   <= DIM_W'(32);
            r_img_w   <= DIM_W'(32);
            r_pad_r   <= '0;
            r_pad_c   <= '0;
            r_step_v  <= STEP_W'(1);
            r_step_h  <= STEP_W'(1);
            r_bias_en <= 1'b1;
            r_relu_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_HEIGHT:    r_img_h   <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_WIDTH:     r_img_w   <= i_cfg_data[DIM_W-1:0];
                CFG_PAD_ROWS:        r_pad_r   <= i_cfg_data[PAD_W-1:0];
                CFG_PAD_COLUMNS:     r_pad_c   <= i_cfg_data[PAD_W-1:0];
                CFG_VERTICAL_STEP:   r_step_v  <= i_cfg_data[STEP_W-1:0];
                CFG_HORIZONTAL_STEP: r_step_h  <= i_cfg_data[STEP_W-1:0];
                CFG_BIAS_ENABLE:     r_bias_en <= i_cfg_data[0];
                CFG_RELU_ENABLE:     r_relu_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective image size and strides
    logic [DIM_W-1:0]  img_h, img_w;
    logic [STEP_W-1:0] step_v, step_h;

    assign img_h  = (32'(r_img_h) > MAX_ROWS)    ? DIM_W'(MAX_ROWS)    : r_img_h;
    assign img_w  = (32'(r_img_w) > MAX_COLUMNS) ? DIM_W'(MAX_COLUMNS) : r_img_w;
    assign step_v = (r_step_v == '0) ? STEP_W'(1) : r_step_v;
    assign step_h = (r_step_h == '0) ? STEP_W'(1) : r_step_h;

    // Store writes
    logic                     wr_pix, wr_wgt, wr_bias;
    logic [PIX_AW-1:0]        pix_waddr;
    logic [WGT_AW-1:0]        wgt_waddr;

    assign wr_pix  = i_cmd.accept && (i_req.req_type == REQ_PIXEL)
                     && (32'(i_req.row) < MAX_ROWS) && (32'(i_req.col) < MAX_COLUMNS)
                     && (32'(i_req.chan) < CHANNELS);
    assign wr_wgt  = i_cmd.accept && (i_req.req_type == REQ_WEIGHT)
                     && (32'(i_req.filter_index) < FILTERS)
                     && (32'(i_req.tap_row) < KERNEL_ROWS)
                     && (32'(i_req.tap_column) < KERNEL_COLUMNS)
                     && (32'(i_req.chan) < CHANNELS);
    assign wr_bias = i_cmd.accept && (i_req.req_type == REQ_BIAS)
                     && (32'(i_req.filter_index) < FILTERS);

    assign pix_waddr = PIX_AW'((32'(i_req.row) * MAX_COLUMNS + 32'(i_req.col)) * CHANNELS
                               + 32'(i_req.chan));
    assign wgt_waddr = WGT_AW'(((32'(i_req.filter_index) * KERNEL_ROWS + 32'(i_req.tap_row))
                                * KERNEL_COLUMNS + 32'(i_req.tap_column)) * CHANNELS
                               + 32'(i_req.chan));

    logic signed [DATA_W-1:0] pix_mem  [PIX_DEPTH];
    logic signed [DATA_W-1:0] wgt_mem  [WGT_DEPTH];
    logic signed [DATA_W-1:0] r_bias   [FILTERS];

    always_ff @(posedge i_clk) begin
        if (wr_pix) begin
            pix_mem[pix_waddr] <= i_req.data_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_wgt) begin
            wgt_mem[wgt_waddr] <= i_req.data_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_bias) begin
            r_bias[BIAS_AW'(i_req.filter_index)] <= i_req.data_value;
        end
    end

    // Hold the compute request
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [FILT_W-1:0] r_filt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_req.req_type == REQ_COMPUTE)) begin
            r_row  <= i_req.row;
            r_col  <= i_req.col;
            r_filt <= i_req.filter_index;
        end
    end

    // Position check: output index valid when index*step + kernel <= padded extent and filter index < FILTERS
    logic [ROW_W+STEP_W-1:0] row_x_step;
    logic [COL_W+STEP_W-1:0] col_x_step;
    logic [DIM_W:0]          span_r, span_c;
    logic                    row_ok, col_ok, filt_ok;

    assign row_x_step = (ROW_W+STEP_W)'(r_row) * (ROW_W+STEP_W)'(step_v);
    assign col_x_step = (COL_W+STEP_W)'(r_col) * (COL_W+STEP_W)'(step_h);
    assign span_r     = (DIM_W+1)'(img_h) + (DIM_W+1)'({r_pad_r, 1'b0});
    assign span_c     = (DIM_W+1)'(img_w) + (DIM_W+1)'({r_pad_c, 1'b0});
    assign row_ok     = (32'(row_x_step) + KERNEL_ROWS) <= 32'(span_r);
    assign col_ok     = (32'(col_x_step) + KERNEL_COLUMNS) <= 32'(span_c);
    assign filt_ok    = 32'(r_filt) < FILTERS;

    // Window origin, registered at the check step
    logic signed [POS_W-1:0] r_base_r, r_base_c;
    logic                    r_invalid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_base_r  <= $signed(POS_W'(row_x_step)) - $signed(POS_W'(r_pad_r));
            r_base_c  <= $signed(POS_W'(col_x_step)) - $signed(POS_W'(r_pad_c));
            r_invalid <= !(row_ok && col_ok && filt_ok);
        end
    end

    // Tap address and bounds
    logic signed [POS_W-1:0] ir, ic;
    logic                    tap_ok;
    logic [PIX_AW-1:0]       pix_raddr;
    logic [WGT_AW-1:0]       wgt_raddr;

    assign ir     = r_base_r + $signed(POS_W'(i_cmd.kr));
    assign ic     = r_base_c + $signed(POS_W'(i_cmd.kc));
    assign tap_ok = !ir[POS_W-1] && (ir < $signed(POS_W'(img_h)))
                    && !ic[POS_W-1] && (ic < $signed(POS_W'(img_w)));

    assign pix_raddr = PIX_AW'((32'(ir[IR_W-1:0]) * MAX_COLUMNS + 32'(ic[IC_W-1:0]))
                               * CHANNELS + 32'(i_cmd.ch));
    assign wgt_raddr = WGT_AW'(((32'(r_filt) * KERNEL_ROWS + 32'(i_cmd.kr))
                                * KERNEL_COLUMNS + 32'(i_cmd.kc)) * CHANNELS
                               + 32'(i_cmd.ch));

    // Stage 1: store reads
    logic signed [DATA_W-1:0] r_pix, r_wgt;
    logic                     r_s1_vld, r_s1_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_pix <= pix_mem[pix_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_wgt <= wgt_mem[wgt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ok <= tap_ok;
    end

    // Stage 2: product, zero for taps outside the image
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_s2_vld;

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            if (r_s1_ok) begin
                r_prod <= r_pix * r_wgt;
            end else begin
                r_prod <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    // Stage 3: accumulate, then add bias scaled to Q24.16
    logic signed [ACC_W-1:0] r_acc;
    logic signed [DATA_W-1:0] bias_val;

    assign bias_val = r_bias[BIAS_AW'(r_filt)];

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_acc <= '0;
        end else if (r_s2_vld) begin
            r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end else if (i_cmd.add_bias && r_bias_en) begin
            r_acc <= r_acc + {{(ACC_W-DATA_W-8){bias_val[DATA_W-1]}}, bias_val, 8'd0};
        end
    end

    // ReLU, round half up to Q7.8, saturate
    logic signed [ACC_W-1:0] relu_acc, rounded, quot;
    logic                    sat_hi, sat_lo;
    logic signed [DATA_W-1:0] res_val;

    assign relu_acc = (r_relu_en && r_acc[ACC_W-1]) ? '0 : r_acc;
    assign rounded  = relu_acc + HALF;
    assign quot     = rounded >>> 8;
    assign sat_hi   = quot > Q_MAX;
    assign sat_lo   = quot < Q_MIN;
    assign res_val  = sat_hi ? Q_MAX[DATA_W-1:0] :
                      sat_lo ? Q_MIN[DATA_W-1:0] : quot[DATA_W-1:0];

    // Result register
    logic r_out_vld;
    t_res r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_res_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_invalid) begin
                r_res.result_value     <= '0;
                r_res.saturated        <= 1'b0;
                r_res.position_invalid <= 1'b1;
            end else begin
                r_res.result_value     <= res_val;
                r_res.saturated        <= sat_hi || sat_lo;
                r_res.position_invalid <= 1'b0;
            end
        end
    end

    assign o_res_valid     = r_out_vld;
    assign o_res           = r_res;
    assign o_sts.pos_ok    = row_ok && col_ok && filt_ok;
    assign o_sts.pipe_busy = r_s1_vld || r_s2_vld;
    assign o_sts.out_free  = !r_out_vld || i_res_ready;

endmodule
